[rtl/pssn_pkg.sv]
// pssn_pkg: shared types, constants and comparator tables for the score sorter
// no dependencies; imported by the sequencer, the store and the top level
package pssn_pkg;

    localparam int SLOTS    = 32;
    localparam int ADDR_W   = 5;
    localparam int CNT_W    = 6;
    localparam int NET8_LEN = 19;
    localparam int NUM_OPS  = 7;
    localparam int OP_W     = 3;
    localparam int K_W      = 5;

    // padded list sizes
    localparam logic [CNT_W-1:0] SIZE_S = 6'd8;
    localparam logic [CNT_W-1:0] SIZE_M = 6'd16;
    localparam logic [CNT_W-1:0] SIZE_L = 6'd32;

    // number of sort/merge operations run for each padded size
    localparam logic [OP_W-1:0] OPS_S = 3'd1;
    localparam logic [OP_W-1:0] OPS_M = 3'd3;
    localparam logic [OP_W-1:0] OPS_L = 3'd7;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_WR,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // one network operation: sort8 on a group, or merge of 2*half slots
    typedef struct packed {
        logic              is_merge;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] half;
    } t_op;

    typedef struct packed {
        logic            start;
        logic            step;
        logic [OP_W-1:0] num_ops;
    } t_seq_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              last;
    } t_seq_st;

    // operation list; the 8 and 16 slot runs are prefixes of the 32 slot run
    function automatic t_op op_at(input logic [OP_W-1:0] idx);
        t_op op;
        case (idx)
            3'd0:    op = '{is_merge: 1'b0, base: 5'd0,  half: 5'd4};
            3'd1:    op = '{is_merge: 1'b0, base: 5'd8,  half: 5'd4};
            3'd2:    op = '{is_merge: 1'b1, base: 5'd0,  half: 5'd8};
            3'd3:    op = '{is_merge: 1'b0, base: 5'd16, half: 5'd4};
            3'd4:    op = '{is_merge: 1'b0, base: 5'd24, half: 5'd4};
            3'd5:    op = '{is_merge: 1'b1, base: 5'd16, half: 5'd8};
            3'd6:    op = '{is_merge: 1'b1, base: 5'd0,  half: 5'd16};
            default: op = '{is_merge: 1'b0, base: 5'd0,  half: 5'd4};
        endcase
        return op;
    endfunction

    // batcher odd-even merge sort on eight slots, {a, b}
    function automatic logic [5:0] net8_pair(input logic [K_W-1:0] k);
        logic [5:0] p;
        case (k)
            5'd0:    p = {3'd0, 3'd1};
            5'd1:    p = {3'd2, 3'd3};
            5'd2:    p = {3'd4, 3'd5};
            5'd3:    p = {3'd6, 3'd7};
            5'd4:    p = {3'd0, 3'd2};
            5'd5:    p = {3'd1, 3'd3};
            5'd6:    p = {3'd4, 3'd6};
            5'd7:    p = {3'd5, 3'd7};
            5'd8:    p = {3'd1, 3'd2};
            5'd9:    p = {3'd5, 3'd6};
            5'd10:   p = {3'd0, 3'd4};
            5'd11:   p = {3'd1, 3'd5};
            5'd12:   p = {3'd2, 3'd6};
            5'd13:   p = {3'd3, 3'd7};
            5'd14:   p = {3'd2, 3'd4};
            5'd15:   p = {3'd3, 3'd5};
            5'd16:   p = {3'd1, 3'd2};
            5'd17:   p = {3'd3, 3'd4};
            5'd18:   p = {3'd5, 3'd6};
            default: p = {3'd0, 3'd1};
        endcase
        return p;
    endfunction

endpackage

[rtl/pssn_if.sv]
// pssn_in_if / pssn_out_if: valid-ready channels for candidates and sorted results
// no dependencies
interface pssn_in_if #(
    parameter int SCORE_BITS = 16,
    parameter int TAG_BITS   = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] score;
    logic        [TAG_BITS-1:0]   tag;
    logic                         last;

    modport source (output valid, score, tag, last, input ready);
    modport sink   (input valid, score, tag, last, output ready);
endinterface

interface pssn_out_if #(
    parameter int SCORE_BITS = 16,
    parameter int TAG_BITS   = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] sorted_score;
    logic        [TAG_BITS-1:0]   sorted_tag;
    logic                         final_res;
    logic                         dropped;

    modport source (output valid, sorted_score, sorted_tag, final_res, dropped, input ready);
    modport sink   (input valid, sorted_score, sorted_tag, final_res, dropped, output ready);
endinterface

[rtl/pssn_store.sv]
// pssn_store: candidate memory, one write port and two registered read ports
// depends on pssn_pkg
module pssn_store import pssn_pkg::*; #(
    parameter int WORD_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0] r_mem [SLOTS];
    logic [WORD_W-1:0] r_rdata_a;
    logic [WORD_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/pssn_seq.sv]
// pssn_seq: walks the comparator sequence and presents one slot pair at a time
// depends on pssn_pkg (operation list, eight slot network)
module pssn_seq import pssn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_ctl i_ctl,
    output t_seq_st  o_st
);

    logic [OP_W-1:0]   r_op;
    logic [OP_W-1:0]   r_num;
    logic [K_W-1:0]    r_k;
    logic [ADDR_W-1:0] r_d;
    logic              r_flip;

    t_op               op;
    logic [5:0]        pr;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] span_m1;
    logic              k_last;
    logic              stage_last;
    logic              op_last;

    always_comb begin
        op      = op_at(r_op);
        pr      = net8_pair(r_k);
        mask    = r_d - 5'd1;
        off     = ((r_k & ~mask) << 1) | (r_k & mask);
        span_m1 = ADDR_W'({1'b0, op.half, 1'b0} - 7'd1);
        if (!op.is_merge) begin
            o_st.a = op.base + {2'b00, pr[5:3]};
            o_st.b = op.base + {2'b00, pr[2:0]};
        end else if (r_flip) begin
            // flip stage: i against 2*half-1-i
            o_st.a = op.base + r_k;
            o_st.b = op.base + (span_m1 - r_k);
        end else begin
            // half-cleaner of distance r_d
            o_st.a = op.base + off;
            o_st.b = op.base + off + r_d;
        end
        k_last     = op.is_merge ? (r_k == op.half - 5'd1) : (r_k == K_W'(NET8_LEN - 1));
        stage_last = !op.is_merge || (!r_flip && r_d == 5'd1);
        op_last    = (r_op == r_num - 3'd1);
        o_st.last  = k_last && stage_last && op_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= '0;
            r_num  <= '0;
            r_k    <= '0;
            r_d    <= '0;
            r_flip <= 1'b1;
        end else if (i_ctl.start) begin
            r_op   <= '0;
            r_num  <= i_ctl.num_ops;
            r_k    <= '0;
            r_flip <= 1'b1;
        end else if (i_ctl.step) begin
            if (!k_last) begin
                r_k <= r_k + 5'd1;
            end else begin
                r_k <= '0;
                if (stage_last) begin
                    if (!op_last) begin
                        r_op <= r_op + 3'd1;
                    end
                    r_flip <= 1'b1;
                end else if (r_flip) begin
                    r_flip <= 1'b0;
                    r_d    <= op.half;
                end else begin
                    r_d <= r_d >> 1;
                end
            end
        end
    end

endmodule

[rtl/padded_score_sort_network_top.sv]
// padded_score_sort_network_top: a closing transfer starts padding, then, for more
// than one entry, sorting (19, 78 or 252 comparators for 8, 16 or 32 slots; each pair
// read, compared and, on a swap, written back slot by slot), then result read-out; the
// pace is set by the one shared compare-exchange unit and the one store write port
// loading takes one transfer per cycle; no transfer is taken while a list pads,
// sorts or is read out
// reset (synchronous, active low) empties the list and the output register only
module padded_score_sort_network_top import pssn_pkg::*; #(
    parameter int MAX_ENTRIES = 32,
    parameter int SCORE_BITS  = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pssn_in_if.sink    i_in,
    pssn_out_if.source o_out
);

    localparam int WORD_W = SCORE_BITS + TAG_BITS;
    localparam logic [WORD_W-1:0] PAD_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf,   n_ovf;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic               r_ov,    n_ov;

    // payload
    logic [WORD_W-1:0]  r_hold,  n_hold;
    logic [WORD_W-1:0]  r_out_word,  n_out_word;
    logic               r_out_final, n_out_final;
    logic               r_out_drop,  n_out_drop;

    // store port
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr_a;
    logic [ADDR_W-1:0]  mem_raddr_b;
    logic [WORD_W-1:0]  mem_rdata_a;
    logic [WORD_W-1:0]  mem_rdata_b;

    t_seq_ctl           seq_ctl;
    t_seq_st            seq_st;

    logic               in_xfer;
    logic               out_xfer;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   padded;
    logic [OP_W-1:0]    num_ops;
    logic signed [SCORE_BITS-1:0] score_a;
    logic signed [SCORE_BITS-1:0] score_b;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_ov && o_out.ready;
    assign cnt_inc  = r_count + 6'd1;
    assign score_a  = mem_rdata_a[WORD_W-1 -: SCORE_BITS];
    assign score_b  = mem_rdata_b[WORD_W-1 -: SCORE_BITS];

    // pad the list to the next of 8, 16 or 32 slots
    always_comb begin
        if (r_count <= SIZE_S) begin
            padded  = SIZE_S;
            num_ops = OPS_S;
        end else if (r_count <= SIZE_M) begin
            padded  = SIZE_M;
            num_ops = OPS_M;
        end else begin
            padded  = SIZE_L;
            num_ops = OPS_L;
        end
    end

    pssn_store #(
        .WORD_W (WORD_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    pssn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .o_st    (seq_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold      <= n_hold;
        r_out_word  <= n_out_word;
        r_out_final <= n_out_final;
        r_out_drop  <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_ov        = r_ov && !out_xfer;
        n_hold      = r_hold;
        n_out_word  = r_out_word;
        n_out_final = r_out_final;
        n_out_drop  = r_out_drop;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[ADDR_W-1:0];
        mem_wdata   = PAD_WORD;
        mem_raddr_a = r_idx[ADDR_W-1:0];
        mem_raddr_b = seq_st.b;
        seq_ctl     = '0;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[ADDR_W-1:0];
                        mem_wdata = {i_in.score, i_in.tag};
                        n_count   = cnt_inc;
                    end else begin
                        // list full: discard and flag the run
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_idx   = n_count;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_idx < padded) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[ADDR_W-1:0];
                    mem_wdata = PAD_WORD;
                    n_idx     = r_idx + 6'd1;
                end else if (r_count > 6'd1) begin
                    seq_ctl.start   = 1'b1;
                    seq_ctl.num_ops = num_ops;
                    n_state         = S_SORT_RD;
                end else begin
                    // single entry goes out unchanged
                    n_idx   = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_SORT_RD: begin
                mem_raddr_a = seq_st.a;
                mem_raddr_b = seq_st.b;
                n_state     = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                // swap only when the upper slot scores strictly lower
                if (score_a < score_b) begin
                    mem_we    = 1'b1;
                    mem_waddr = seq_st.a;
                    mem_wdata = mem_rdata_b;
                    n_hold    = mem_rdata_a;
                    n_state   = S_SORT_WR;
                end else begin
                    seq_ctl.step = 1'b1;
                    if (seq_st.last) begin
                        n_idx   = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_state = S_SORT_RD;
                    end
                end
            end
            S_SORT_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = seq_st.b;
                mem_wdata    = r_hold;
                seq_ctl.step = 1'b1;
                if (seq_st.last) begin
                    n_idx   = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_SORT_RD;
                end
            end
            S_OUT_RD: begin
                // read once the output register is free by the next edge
                if (!r_ov || o_out.ready) begin
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                n_ov        = 1'b1;
                n_out_word  = mem_rdata_a;
                n_out_final = (r_idx + 6'd1 == r_count);
                n_out_drop  = r_ovf;
                if (r_idx + 6'd1 == r_count) begin
                    // last result loaded: reopen the list while it drains
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_idx   = r_idx + 6'd1;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_ov;
    assign o_out.sorted_score = r_out_word[WORD_W-1 -: SCORE_BITS];
    assign o_out.sorted_tag   = r_out_word[TAG_BITS-1:0];
    assign o_out.final_res    = r_out_final;
    assign o_out.dropped      = r_out_drop;

    // a transfer into a full list leaves the overflow flag set
    a_ovf_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_count == CNT_W'(MAX_ENTRIES)) |=> r_ovf)
        else $error("overflow not flagged on full list");

    // a closing transfer always starts padding
    a_close_pads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.last) |=> (r_state == S_PAD))
        else $error("closing transfer did not start padding");

    // the output register is empty whenever a result is loaded
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_LD) |-> !r_ov)
        else $error("result loaded over a pending result");

    // the store is not written while reading pairs or results
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_RD || r_state == S_OUT_RD || r_state == S_OUT_LD) |-> !mem_we)
        else $error("store written in a read state");

endmodule

[tb/padded_score_sort_network_top_tb.sv]
// padded_score_sort_network_top_tb: self-checking bench for the padded score sorter
// depends on pssn_pkg, pssn_in_if / pssn_out_if and padded_score_sort_network_top
// a directed table and random lists are checked against a local sorting network model
`timescale 1ns / 100ps

module padded_score_sort_network_top_tb;

    localparam int MAX_CANDS      = 32;
    localparam int RANDOM_ITEMS   = 390;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 900;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_DIRECTED   = 19;

    // one kept candidate, and one ranked result as it leaves the block
    typedef struct packed {
        logic [15:0] score;
        logic [15:0] tag;
    } t_cand;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] tag;
        logic        final_res;
        logic        dropped;
    } t_rank;

    // directed row: one candidate, with a typed expectation for single entry lists
    typedef struct packed {
        logic [15:0] score;
        logic [15:0] tag;
        logic        last;
        logic        typed;
        t_rank       want;
    } t_row;

    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    localparam t_cand PAD_CAND = '{score: 16'h8000, tag: 16'h0000};
    localparam t_rank NO_RANK  = '0;

    // batcher odd-even merge sort on eight slots
    localparam int BATCHER_PAIRS [19][2] = '{
        '{0, 1}, '{2, 3}, '{4, 5}, '{6, 7},
        '{0, 2}, '{1, 3}, '{4, 6}, '{5, 7},
        '{1, 2}, '{5, 6},
        '{0, 4}, '{1, 5}, '{2, 6}, '{3, 7},
        '{2, 4}, '{3, 5},
        '{1, 2}, '{3, 4}, '{5, 6}
    };

    // singles read straight off the table, the rest left to the model
    localparam t_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'h7fff, 16'hffff, 1'b1, 1'b1, '{16'h7fff, 16'hffff, 1'b1, 1'b0}},
        '{16'h8000, 16'h0000, 1'b1, 1'b1, '{16'h8000, 16'h0000, 1'b1, 1'b0}},
        '{16'h0000, 16'h5a5a, 1'b1, 1'b1, '{16'h0000, 16'h5a5a, 1'b1, 1'b0}},
        '{16'h8000, 16'h1234, 1'b1, 1'b1, '{16'h8000, 16'h1234, 1'b1, 1'b0}},
        '{16'hffff, 16'h0001, 1'b0, 1'b0, NO_RANK},
        '{16'h0001, 16'h0002, 1'b1, 1'b0, NO_RANK},
        '{16'h0005, 16'h0001, 1'b0, 1'b0, NO_RANK},
        '{16'h0005, 16'h0002, 1'b0, 1'b0, NO_RANK},
        '{16'hfffd, 16'h0003, 1'b0, 1'b0, NO_RANK},
        '{16'h7fff, 16'h0004, 1'b0, 1'b0, NO_RANK},
        '{16'h0005, 16'h0005, 1'b0, 1'b0, NO_RANK},
        '{16'h8000, 16'h0006, 1'b0, 1'b0, NO_RANK},
        '{16'hfffd, 16'h0007, 1'b0, 1'b0, NO_RANK},
        '{16'h0005, 16'h0008, 1'b1, 1'b0, NO_RANK},
        '{16'h8000, 16'h000a, 1'b0, 1'b0, NO_RANK},
        '{16'h8000, 16'h000b, 1'b0, 1'b0, NO_RANK},
        '{16'h0010, 16'h000c, 1'b1, 1'b0, NO_RANK},
        '{16'h0100, 16'haaaa, 1'b0, 1'b0, NO_RANK},
        '{16'h0100, 16'h5555, 1'b1, 1'b0, NO_RANK}
    };

    localparam int BOUNDARY_LENS [8] = '{1, 2, 8, 9, 16, 17, 32, 33};

    logic i_clk;
    logic i_rst_n;

    pssn_in_if  #(.SCORE_BITS(16), .TAG_BITS(16)) cand_if ();
    pssn_out_if #(.SCORE_BITS(16), .TAG_BITS(16)) rank_if ();

    padded_score_sort_network_top #(
        .MAX_ENTRIES (MAX_CANDS),
        .SCORE_BITS  (16),
        .TAG_BITS    (16)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cand_if),
        .o_out   (rank_if)
    );

    // model state: the list being gathered, the overflow flag and the sort workspace
    t_cand      held_cands [$];
    logic       spilled;
    t_cand      slot_buf [32];
    t_rank      expected_ranks [$];

    t_idle_mode idle_mode;
    bit         hold_request;
    int         holds_done    = 0;
    int         error_count   = 0;
    int         ranks_checked = 0;
    int         lists_closed;
    int         overflow_runs;
    int         input_transfers;
    int         quiet_cycles  = 0;

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // swap only when the upper slot scores strictly lower, so ties stay put
    task automatic compare_exchange(input int a, input int b);
        t_cand tmp;
        if ($signed(slot_buf[a].score) < $signed(slot_buf[b].score)) begin
            tmp         = slot_buf[a];
            slot_buf[a] = slot_buf[b];
            slot_buf[b] = tmp;
        end
    endtask

    task automatic batcher8(input int base);
        int k;
        for (k = 0; k < 19; k++) begin
            compare_exchange(base + BATCHER_PAIRS[k][0], base + BATCHER_PAIRS[k][1]);
        end
    endtask

    // flip stage then half-cleaners over n slots whose halves are sorted
    task automatic merge_run(input int base, input int n);
        int i;
        int d;
        int blk;
        for (i = 0; i < n / 2; i++) begin
            compare_exchange(base + i, base + n - 1 - i);
        end
        for (d = n / 2; d >= 1; d = d / 2) begin
            for (blk = 0; blk < n; blk += 2 * d) begin
                for (i = 0; i < d; i++) begin
                    compare_exchange(base + blk + i, base + blk + i + d);
                end
            end
        end
    endtask

    // pad, sort and queue the ranked results of the list just closed
    task automatic close_list(input bit emit);
        int    n;
        int    padded;
        int    i;
        int    g;
        t_rank r;
        n      = held_cands.size();
        padded = (n <= 8) ? 8 : ((n <= 16) ? 16 : 32);
        for (i = 0; i < 32; i++) begin
            slot_buf[i] = (i < n) ? held_cands[i] : PAD_CAND;
        end
        // groups are disjoint, so running all eights before the merges is equivalent
        if (n > 1) begin
            for (g = 0; g < padded; g += 8) begin
                batcher8(g);
            end
            if (padded >= 16) begin
                for (g = 0; g < padded; g += 16) begin
                    merge_run(g, 16);
                end
            end
            if (padded == 32) begin
                merge_run(0, 32);
            end
        end
        if (emit) begin
            for (i = 0; i < n; i++) begin
                r.score     = slot_buf[i].score;
                r.tag       = slot_buf[i].tag;
                r.final_res = (i == n - 1);
                r.dropped   = spilled;
                expected_ranks.push_back(r);
            end
        end
        lists_closed++;
        if (spilled) begin
            overflow_runs++;
        end
        held_cands.delete();
        spilled = 1'b0;
    endtask

    // offer one candidate from a falling edge, hold it until the transfer,
    // then update the model; valid stays high into the next item unless a gap is drawn
    task automatic offer_candidate(input logic [15:0] score, input logic [15:0] tag,
                                   input logic last, input logic typed, input t_rank want);
        t_cand c;
        c.score = score;
        c.tag   = tag;
        while ($urandom_range(0, 99) < ((idle_mode == IDLE_RX_HEAVY) ? 12 :
                                        ((idle_mode == IDLE_TX_HEAVY) ? 56 : 0))) begin
            cand_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cand_if.valid <= 1'b1;
        cand_if.score <= score;
        cand_if.tag   <= tag;
        cand_if.last  <= last;
        do begin
            @(posedge i_clk);
        end while (!cand_if.ready);
        input_transfers++;
        // beyond capacity the candidate is lost, closing one included
        if (held_cands.size() < MAX_CANDS) begin
            held_cands.push_back(c);
        end else begin
            spilled = 1'b1;
        end
        if (last) begin
            if (typed) begin
                expected_ranks.push_back(want);
            end
            close_list(!typed);
        end
        @(negedge i_clk);
    endtask

    task automatic check_rank();
        t_rank want;
        if (expected_ranks.size() == 0) begin
            flag_mismatch($sformatf("result with nothing expected: score %0d tag %h",
                                    $signed(rank_if.sorted_score), rank_if.sorted_tag));
        end else begin
            want = expected_ranks.pop_front();
            ranks_checked++;
            if (rank_if.sorted_score !== want.score) begin
                flag_mismatch($sformatf("sorted_score %0d, expected %0d",
                                        $signed(rank_if.sorted_score), $signed(want.score)));
            end
            if (rank_if.sorted_tag !== want.tag) begin
                flag_mismatch($sformatf("sorted_tag %h, expected %h",
                                        rank_if.sorted_tag, want.tag));
            end
            if (rank_if.final_res !== want.final_res) begin
                flag_mismatch($sformatf("final_res %b, expected %b",
                                        rank_if.final_res, want.final_res));
            end
            if (rank_if.dropped !== want.dropped) begin
                flag_mismatch($sformatf("dropped %b, expected %b",
                                        rank_if.dropped, want.dropped));
            end
        end
    endtask

    // result checking and the watchdog, both on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rank_if.valid && rank_if.ready) begin
                check_rank();
            end
            if ((rank_if.valid && rank_if.ready) || (cand_if.valid && cand_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_ranks.size());
                $display("** padded_score_sort_network_top: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left     = 0;
        rank_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request && holds_done == 0) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rank_if.ready <= 1'b0;
            end else begin
                rank_if.ready <= ($urandom_range(0, 99) >=
                                  ((idle_mode == IDLE_RX_HEAVY) ? 56 :
                                   ((idle_mode == IDLE_TX_HEAVY) ? 12 : 0)));
            end
        end
    end

    // sender: reset, directed table, random lists, then drain and verdict
    initial begin
        int          list_len;
        int          roll;
        int          k;
        int          random_sent;
        logic [15:0] draw_score;

        spilled         = 1'b0;
        idle_mode       = IDLE_RX_HEAVY;
        hold_request    = 1'b0;
        lists_closed    = 0;
        overflow_runs   = 0;
        input_transfers = 0;
        random_sent     = 0;

        i_rst_n       <= 1'b0;
        cand_if.valid <= 1'b0;
        cand_if.score <= '0;
        cand_if.tag   <= '0;
        cand_if.last  <= 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single entries, ties among themselves and with padding
        for (k = 0; k < NUM_DIRECTED; k++) begin
            offer_candidate(DIRECTED_ROWS[k].score, DIRECTED_ROWS[k].tag,
                            DIRECTED_ROWS[k].last, DIRECTED_ROWS[k].typed,
                            DIRECTED_ROWS[k].want);
        end

        // random lists, mostly short, with size boundaries and overflow mixed in
        while (random_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                list_len = BOUNDARY_LENS[$urandom_range(0, 7)];
            end else if (roll < 55) begin
                list_len = $urandom_range(1, 8);
            end else if (roll < 78) begin
                list_len = $urandom_range(9, 16);
            end else if (roll < 91) begin
                list_len = $urandom_range(17, 32);
            end else begin
                list_len = $urandom_range(33, 38);
            end
            for (k = 0; k < list_len; k++) begin
                // swap the idling sides, then run flat out behind a long receiver stall
                if (random_sent == RANDOM_ITEMS / 3) begin
                    idle_mode = IDLE_TX_HEAVY;
                end else if (random_sent == (2 * RANDOM_ITEMS) / 3) begin
                    idle_mode    = IDLE_NONE;
                    hold_request = 1'b1;
                end
                // bias scores towards extremes and near ties
                case ($urandom_range(0, 9))
                    0:       draw_score = 16'h8000;
                    1:       draw_score = 16'h7fff;
                    2, 3, 4: draw_score = 16'($urandom_range(0, 3)) - 16'd2;
                    default: draw_score = 16'($urandom);
                endcase
                offer_candidate(draw_score, 16'($urandom), (k == list_len - 1), 1'b0,
                                NO_RANK);
                random_sent++;
            end
        end
        cand_if.valid <= 1'b0;

        // wait out the outstanding results, then watch for strays
        while (expected_ranks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d candidate transfers in %0d lists, %0d of them over capacity",
                 input_transfers, lists_closed, overflow_runs);
        $display("run: %0d ranked results checked, %0d long receiver hold-off(s)",
                 ranks_checked, holds_done);
        if (error_count == 0 && expected_ranks.size() == 0) begin
            $display("** padded_score_sort_network_top: PASSED **");
        end else begin
            $display("** padded_score_sort_network_top: FAILED **");
        end
        $finish;
    end

endmodule
